// ===== rtl/sui_pkg.sv =====
// Shared types and constants for the sorted unique id set.
`timescale 1ns / 1ps
`default_nettype none
package sui_pkg;

   localparam int ID_W     = 64;
   localparam int STATUS_W = 3;
   localparam int FIELD_W  = 7;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_INVALID  = 3'd2,
      ST_OWNER    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // What a cell shows to its right-hand neighbor.
   typedef struct packed {
      logic [ID_W-1:0] entry;
      logic            valid;
      logic            lt;
   } cell_link_type;

   // Strobes broadcast to every cell.
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/sui_req_if.sv =====
// Request channel: one id per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface sui_req_if;
   logic                      valid;
   logic                      ready;
   logic [sui_pkg::ID_W-1:0]  new_id;

   modport source (output valid, output new_id, input ready);
   modport sink   (input valid, input new_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/sui_rsp_if.sv =====
// Response channel: status, position and entry total per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface sui_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sui_pkg::STATUS_W-1:0] status;
   logic [sui_pkg::FIELD_W-1:0]  position;
   logic [sui_pkg::FIELD_W-1:0]  entry_total;

   modport source (output valid, output status, output position, output entry_total,
                   input ready);
   modport sink   (input valid, input status, input position, input entry_total,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_unique_id_set_insert.sv =====
// Top level: sorted unique id set with compare-and-shift cell row.
// Usage:
//   req_chan (valid/ready) carries one 64-bit new_id per transaction.
//   rsp_chan (valid/ready) returns one transaction per request: status,
//   lower-bound position and entry total after the insert.
//   csr_wr_en/csr_wr_data write owner_id; write only while the block is idle.
// Timing:
//   An accepted id passes through capture, compare in every cell, then
//   shift-insert and load of the response register. The next request is
//   accepted only once the block is back in idle, so a new id cannot be
//   taken before the last one is through the update step.
// Stall: a response waits in its output register; the block still accepts
//   and compares the next id, and holds in the update step until the
//   pending response is taken.
// Reset: synchronous, active high. Clears the entry count, all cell valid
//   bits, owner_id and the response valid; no clearing pass is needed.
// Status codes: inserted, already present, invalid (zero id), equals owner,
//   store full. Invalid and owner-matching ids report position 0.
`timescale 1ns / 1ps
`default_nettype none
module sorted_unique_id_set_insert #(
   parameter int CAPACITY = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   sui_req_if.sink                       req_chan,
   sui_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_wr_en,
   input  wire logic [sui_pkg::ID_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam int FW    = sui_pkg::FIELD_W;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_COMPARE = 3'b010,
      S_UPDATE  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [sui_pkg::ID_W-1:0] owner_ff;
   logic [sui_pkg::ID_W-1:0] key_ff, key_in;
   logic                     zero_ff, zero_in;
   logic                     is_owner_ff, is_owner_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   sui_pkg::status_type      status_ff, status_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         total_ff, total_in;

   sui_pkg::cell_ctrl_type   ctrl;
   logic [CNT_W-1:0]         row_pos;
   logic                     row_present;
   logic [CAPACITY-1:0]      valid_vec;

   logic                     req_fire;
   logic                     out_free;

   sui_row #(.CAPACITY(CAPACITY)) u_row (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .key       (key_ff),
      .pos       (row_pos),
      .present   (row_present),
      .valid_vec (valid_vec)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      zero_in      = zero_ff;
      is_owner_in  = is_owner_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ctrl.cmp_en  = 1'b0;
      ctrl.ins_en  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in   = req_chan.new_id;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            // every cell compares its entry against the key in parallel
            ctrl.cmp_en = 1'b1;
            zero_in     = (key_ff == '0);
            is_owner_in = (key_ff == owner_ff);
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               total_in     = count_ff;
               pos_in       = row_pos;
               if (zero_ff) begin
                  status_in = sui_pkg::ST_INVALID;
                  pos_in    = '0;
               end else if (is_owner_ff) begin
                  status_in = sui_pkg::ST_OWNER;
                  pos_in    = '0;
               end else if (row_present) begin
                  status_in = sui_pkg::ST_PRESENT;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = sui_pkg::ST_FULL;
               end else begin
                  // shift-insert across the row
                  status_in   = sui_pkg::ST_INSERTED;
                  ctrl.ins_en = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  total_in    = count_in;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         owner_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            owner_ff <= csr_wr_data;
         end
      end
      key_ff      <= key_in;
      zero_ff     <= zero_in;
      is_owner_ff <= is_owner_in;
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      total_ff    <= total_in;
   end

   // fit internal counts to the 7-bit response fields
   logic [CNT_W+FW-1:0] pos_wide;
   logic [CNT_W+FW-1:0] total_wide;
   assign pos_wide   = {{FW{1'b0}}, pos_ff};
   assign total_wide = {{FW{1'b0}}, total_ff};

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.position    = pos_wide[FW-1:0];
   assign rsp_chan.entry_total = total_wide[FW-1:0];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_vec) == int'(count_ff)))
      else $error("cell valid bits disagree with entry count");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == sui_pkg::ST_FULL) |-> (total_ff == CNT_W'(CAPACITY)))
      else $error("full status with room left");

   a_insert_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == sui_pkg::ST_INSERTED) |-> (pos_ff < total_ff))
      else $error("insert position outside the list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the count");
`endif

endmodule
`default_nettype wire

// ===== rtl/sui_cell.sv =====
// One storage cell: holds an id, compares it to the key, shifts right on insert.
`timescale 1ns / 1ps
`default_nettype none
module sui_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sui_pkg::cell_ctrl_type   ctrl,
   input  wire logic [sui_pkg::ID_W-1:0] key,
   input  wire sui_pkg::cell_link_type   left,
   output sui_pkg::cell_link_type        self_link,
   output logic                          eq,
   output logic                          boundary
);

   logic [sui_pkg::ID_W-1:0] entry_ff, entry_in;
   logic                     valid_ff, valid_in;
   logic                     lt_ff, lt_in;
   logic                     eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.cmp_en) begin
         lt_in = valid_ff && (entry_ff < key);
         eq_in = valid_ff && (entry_ff == key);
      end
      // cells below the insert point hold; the boundary cell takes the key;
      // cells above take their left neighbor
      if (ctrl.ins_en && !lt_ff) begin
         if (left.lt) begin
            entry_in = key;
            valid_in = 1'b1;
         end else begin
            entry_in = left.entry;
            valid_in = left.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
      end
      entry_ff <= entry_in;
   end

   assign self_link.entry = entry_ff;
   assign self_link.valid = valid_ff;
   assign self_link.lt    = lt_ff;
   assign eq              = eq_ff;
   assign boundary        = !lt_ff && left.lt;

endmodule
`default_nettype wire

// ===== rtl/sui_row.sv =====
// Row of cells plus the encoder for the lower-bound position.
`timescale 1ns / 1ps
`default_nettype none
module sui_row #(
   parameter int CAPACITY = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sui_pkg::cell_ctrl_type     ctrl,
   input  wire logic [sui_pkg::ID_W-1:0]   key,
   output logic [$clog2(CAPACITY+1)-1:0]   pos,
   output logic                            present,
   output logic [CAPACITY-1:0]             valid_vec
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   sui_pkg::cell_link_type link [CAPACITY+1];
   logic [CAPACITY-1:0]    eq_vec;
   logic [CAPACITY-1:0]    bnd_vec;

   // left edge: everything "before" cell 0 counts as less than the key
   assign link[0].entry = '0;
   assign link[0].valid = 1'b1;
   assign link[0].lt    = 1'b1;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      sui_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .key       (key),
         .left      (link[g]),
         .self_link (link[g+1]),
         .eq        (eq_vec[g]),
         .boundary  (bnd_vec[g])
      );
      assign valid_vec[g] = link[g+1].valid;
   end

   // boundary is one-hot (or empty when every cell is below the key)
   always_comb begin
      logic [CNT_W-1:0] acc;
      acc     = '0;
      present = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (bnd_vec[i]) begin
            acc = acc | CNT_W'(i);
         end
         present = present | (bnd_vec[i] & eq_vec[i]);
      end
      pos = (|bnd_vec) ? acc : CNT_W'(CAPACITY);
   end

endmodule
`default_nettype wire
